// ===== sv/segment_rectangle_hit_scan_assert.svh =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - assertion macros
// Shared concurrent assertion forms for the hit scan checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECTANGLE_HIT_SCAN_ASSERT_SVH
`define SEGMENT_RECTANGLE_HIT_SCAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srhs_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - package
// Register map, orientation codes and stage control types.
// ----------------------------------------------------------------------------
package srhs_pkg;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    localparam int NUM_CORNERS = 4;
    localparam int NUM_EDGES   = 4;

    // Corners: left-bottom, left-top, right-bottom, right-top
    localparam int CORNER_LB = 0;
    localparam int CORNER_LT = 1;
    localparam int CORNER_RB = 2;
    localparam int CORNER_RT = 3;

    // Edge end points; the first corner is never above or right of the second
    localparam int EDGE_A [NUM_EDGES] = '{CORNER_LB, CORNER_LB, CORNER_LT, CORNER_RB};
    localparam int EDGE_B [NUM_EDGES] = '{CORNER_LT, CORNER_RB, CORNER_RT, CORNER_RT};

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_RAY_START_X = 3'd0,
        REG_RAY_START_Y = 3'd1,
        REG_RAY_END_X   = 3'd2,
        REG_RAY_END_Y   = 3'd3,
        REG_IGNORE_MASK = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ORI_COLLINEAR = 2'd0,
        ORI_CW        = 2'd1,
        ORI_CCW       = 2'd2
    } orient_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic skip;
    } stage_ctl_t;

    typedef struct packed {
        orient_t o_start;
        orient_t o_end;
        logic    start_on;
        logic    end_on;
    } edge_info_t;

endpackage

// ===== sv/srhs_if.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - channel interfaces
// Rectangle input channel and hit result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srhs_rect_if #(
    parameter int COORD_BITS = 16,
    parameter int MASK_BITS  = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [COORD_BITS-1:0] rect_width;
    logic        [COORD_BITS-1:0] rect_height;
    logic        [MASK_BITS-1:0]  layer_bits;
    logic                         last_rect;

    modport source (
        output valid, center_x, center_y, rect_width, rect_height, layer_bits, last_rect,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, rect_width, rect_height, layer_bits, last_rect,
        output ready
    );
endinterface

interface srhs_result_if;
    logic valid;
    logic ready;
    logic rect_hit;
    logic any_hit;
    logic run_end;

    modport source (
        output valid, rect_hit, any_hit, run_end,
        input  ready
    );

    modport sink (
        input  valid, rect_hit, any_hit, run_end,
        output ready
    );
endinterface

// ===== sv/srhs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - configuration registers
// APB-style register file holding the ray end points and the ignore mask.
// ----------------------------------------------------------------------------
module srhs_cfg_regs #(
    parameter int COORD_BITS = 16,
    parameter int MASK_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [srhs_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [srhs_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [srhs_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output logic signed [COORD_BITS-1:0]         ray_start_x,
    output logic signed [COORD_BITS-1:0]         ray_start_y,
    output logic signed [COORD_BITS-1:0]         ray_end_x,
    output logic signed [COORD_BITS-1:0]         ray_end_y,
    output logic [MASK_BITS-1:0]                 ignore_mask
);
    import srhs_pkg::*;

    logic signed [COORD_BITS-1:0] ray_start_x_reg;
    logic signed [COORD_BITS-1:0] ray_start_y_reg;
    logic signed [COORD_BITS-1:0] ray_end_x_reg;
    logic signed [COORD_BITS-1:0] ray_end_y_reg;
    logic [MASK_BITS-1:0]         ignore_mask_reg;
    logic                         wr_en;
    reg_idx_t                     reg_idx;

    // word address; byte lane bits are ignored
    assign reg_idx = reg_idx_t'(paddr[2 +: REG_IDX_BITS]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_start_x_reg <= '0;
            ray_start_y_reg <= '0;
            ray_end_x_reg   <= '0;
            ray_end_y_reg   <= '0;
            ignore_mask_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RAY_START_X: ray_start_x_reg <= pwdata[COORD_BITS-1:0];
                REG_RAY_START_Y: ray_start_y_reg <= pwdata[COORD_BITS-1:0];
                REG_RAY_END_X:   ray_end_x_reg   <= pwdata[COORD_BITS-1:0];
                REG_RAY_END_Y:   ray_end_y_reg   <= pwdata[COORD_BITS-1:0];
                REG_IGNORE_MASK: ignore_mask_reg <= pwdata[MASK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RAY_START_X: prdata = APB_DATA_BITS'($unsigned(ray_start_x_reg));
            REG_RAY_START_Y: prdata = APB_DATA_BITS'($unsigned(ray_start_y_reg));
            REG_RAY_END_X:   prdata = APB_DATA_BITS'($unsigned(ray_end_x_reg));
            REG_RAY_END_Y:   prdata = APB_DATA_BITS'($unsigned(ray_end_y_reg));
            REG_IGNORE_MASK: prdata = APB_DATA_BITS'(ignore_mask_reg);
            default:         prdata = '0;
        endcase
    end

    assign ray_start_x = ray_start_x_reg;
    assign ray_start_y = ray_start_y_reg;
    assign ray_end_x   = ray_end_x_reg;
    assign ray_end_y   = ray_end_y_reg;
    assign ignore_mask = ignore_mask_reg;

endmodule

// ===== sv/srhs_geom.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - geometry stage
// Forms corners in doubled coordinates, the ray cross products per corner,
// edge orientations and box tests, and registers them.
// ----------------------------------------------------------------------------
module srhs_geom #(
    parameter int COORD_BITS = 16,
    parameter int MASK_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic [COORD_BITS-1:0]         rect_width,
    input  logic [COORD_BITS-1:0]         rect_height,
    input  logic [MASK_BITS-1:0]          layer_bits,
    input  logic                          last_rect,
    input  logic signed [COORD_BITS-1:0]  ray_start_x,
    input  logic signed [COORD_BITS-1:0]  ray_start_y,
    input  logic signed [COORD_BITS-1:0]  ray_end_x,
    input  logic signed [COORD_BITS-1:0]  ray_end_y,
    input  logic [MASK_BITS-1:0]          ignore_mask,
    output srhs_pkg::stage_ctl_t          ctl,
    output logic signed [2*COORD_BITS+4:0] prod_a [srhs_pkg::NUM_CORNERS],
    output logic signed [2*COORD_BITS+4:0] prod_b [srhs_pkg::NUM_CORNERS],
    output srhs_pkg::edge_info_t          edge_info [srhs_pkg::NUM_EDGES],
    output logic                          corner_on [srhs_pkg::NUM_CORNERS]
);
    import srhs_pkg::*;

    localparam int PT_BITS   = COORD_BITS + 2;
    localparam int DIF_BITS  = COORD_BITS + 3;
    localparam int PROD_BITS = 2 * COORD_BITS + 5;

    // left and right edges are vertical
    localparam bit EDGE_VERT [NUM_EDGES] = '{1'b1, 1'b0, 1'b0, 1'b1};

    logic signed [PT_BITS-1:0]   cx2, cy2, ext_w, ext_h;
    logic signed [PT_BITS-1:0]   rsx, rsy, rex, rey, ray_dx, ray_dy;
    logic signed [PT_BITS-1:0]   ray_xmin, ray_xmax, ray_ymin, ray_ymax;
    logic signed [PT_BITS-1:0]   crn_x [NUM_CORNERS];
    logic signed [PT_BITS-1:0]   crn_y [NUM_CORNERS];
    logic signed [DIF_BITS-1:0]  off_x [NUM_CORNERS];
    logic signed [DIF_BITS-1:0]  off_y [NUM_CORNERS];
    logic signed [PROD_BITS-1:0] prod_a_next [NUM_CORNERS];
    logic signed [PROD_BITS-1:0] prod_b_next [NUM_CORNERS];
    logic signed [PROD_BITS-1:0] prod_a_reg [NUM_CORNERS];
    logic signed [PROD_BITS-1:0] prod_b_reg [NUM_CORNERS];
    edge_info_t                  edge_next [NUM_EDGES];
    edge_info_t                  edge_reg [NUM_EDGES];
    logic                        corner_on_next [NUM_CORNERS];
    logic                        corner_on_reg [NUM_CORNERS];
    logic                        skip_next;
    logic                        valid_reg;
    logic                        last_reg;
    logic                        skip_reg;

    // orientation of a point against an axis-aligned edge of non-zero length
    function automatic orient_t axis_orient(
        logic signed [PT_BITS-1:0] pos,
        logic signed [PT_BITS-1:0] line,
        logic                      nonzero,
        logic                      flip
    );
        orient_t o;
        if (!nonzero || pos == line)
            o = ORI_COLLINEAR;
        else if ((pos > line) ^ flip)
            o = ORI_CW;
        else
            o = ORI_CCW;
        return o;
    endfunction

    function automatic logic in_box(
        logic signed [PT_BITS-1:0] px,
        logic signed [PT_BITS-1:0] py,
        logic signed [PT_BITS-1:0] xlo,
        logic signed [PT_BITS-1:0] xhi,
        logic signed [PT_BITS-1:0] ylo,
        logic signed [PT_BITS-1:0] yhi
    );
        return (px >= xlo) && (px <= xhi) && (py >= ylo) && (py <= yhi);
    endfunction

    // doubled coordinates keep the half-size edges exact
    assign cx2   = PT_BITS'(center_x) <<< 1;
    assign cy2   = PT_BITS'(center_y) <<< 1;
    assign ext_w = signed'(PT_BITS'(rect_width));
    assign ext_h = signed'(PT_BITS'(rect_height));
    assign rsx   = PT_BITS'(ray_start_x) <<< 1;
    assign rsy   = PT_BITS'(ray_start_y) <<< 1;
    assign rex   = PT_BITS'(ray_end_x) <<< 1;
    assign rey   = PT_BITS'(ray_end_y) <<< 1;

    assign ray_dx   = rex - rsx;
    assign ray_dy   = rey - rsy;
    assign ray_xmin = (rsx < rex) ? rsx : rex;
    assign ray_xmax = (rsx > rex) ? rsx : rex;
    assign ray_ymin = (rsy < rey) ? rsy : rey;
    assign ray_ymax = (rsy > rey) ? rsy : rey;

    assign crn_x[CORNER_LB] = cx2 - ext_w;
    assign crn_y[CORNER_LB] = cy2 - ext_h;
    assign crn_x[CORNER_LT] = cx2 - ext_w;
    assign crn_y[CORNER_LT] = cy2 + ext_h;
    assign crn_x[CORNER_RB] = cx2 + ext_w;
    assign crn_y[CORNER_RB] = cy2 - ext_h;
    assign crn_x[CORNER_RT] = cx2 + ext_w;
    assign crn_y[CORNER_RT] = cy2 + ext_h;

    assign skip_next = |(layer_bits & ignore_mask);

    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            off_x[c]          = DIF_BITS'(crn_x[c]) - DIF_BITS'(rex);
            off_y[c]          = DIF_BITS'(crn_y[c]) - DIF_BITS'(rey);
            prod_a_next[c]    = PROD_BITS'(ray_dy) * PROD_BITS'(off_x[c]);
            prod_b_next[c]    = PROD_BITS'(ray_dx) * PROD_BITS'(off_y[c]);
            corner_on_next[c] = in_box(crn_x[c], crn_y[c], ray_xmin, ray_xmax,
                                       ray_ymin, ray_ymax);
        end
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            if (EDGE_VERT[e])
            begin
                edge_next[e].o_start = axis_orient(rsx, crn_x[EDGE_B[e]],
                                                   rect_height != '0, 1'b0);
                edge_next[e].o_end   = axis_orient(rex, crn_x[EDGE_B[e]],
                                                   rect_height != '0, 1'b0);
            end
            else
            begin
                edge_next[e].o_start = axis_orient(rsy, crn_y[EDGE_B[e]],
                                                   rect_width != '0, 1'b1);
                edge_next[e].o_end   = axis_orient(rey, crn_y[EDGE_B[e]],
                                                   rect_width != '0, 1'b1);
            end
            edge_next[e].start_on = in_box(rsx, rsy, crn_x[EDGE_A[e]], crn_x[EDGE_B[e]],
                                           crn_y[EDGE_A[e]], crn_y[EDGE_B[e]]);
            edge_next[e].end_on   = in_box(rex, rey, crn_x[EDGE_A[e]], crn_x[EDGE_B[e]],
                                           crn_y[EDGE_A[e]], crn_y[EDGE_B[e]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= last_rect;
            skip_reg <= skip_next;
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                prod_a_reg[c]    <= prod_a_next[c];
                prod_b_reg[c]    <= prod_b_next[c];
                corner_on_reg[c] <= corner_on_next[c];
            end
            for (int e = 0; e < NUM_EDGES; e++)
                edge_reg[e] <= edge_next[e];
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.last  = last_reg;
    assign ctl.skip  = skip_reg;
    assign prod_a    = prod_a_reg;
    assign prod_b    = prod_b_reg;
    assign edge_info = edge_reg;
    assign corner_on = corner_on_reg;

endmodule

// ===== sv/srhs_decide.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - decision logic
// Signs the corner cross products and combines the crossing tests of all edges.
// ----------------------------------------------------------------------------
module srhs_decide #(
    parameter int COORD_BITS = 16
) (
    input  logic                           skip,
    input  logic signed [2*COORD_BITS+4:0] prod_a [srhs_pkg::NUM_CORNERS],
    input  logic signed [2*COORD_BITS+4:0] prod_b [srhs_pkg::NUM_CORNERS],
    input  srhs_pkg::edge_info_t           edge_info [srhs_pkg::NUM_EDGES],
    input  logic                           corner_on [srhs_pkg::NUM_CORNERS],
    output logic                           hit
);
    import srhs_pkg::*;

    localparam int PROD_BITS  = 2 * COORD_BITS + 5;
    localparam int CROSS_BITS = PROD_BITS + 1;

    logic signed [CROSS_BITS-1:0] cross_z [NUM_CORNERS];
    orient_t                      c_or [NUM_CORNERS];
    logic [NUM_EDGES-1:0]         edge_hit;

    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            cross_z[c] = CROSS_BITS'(prod_a[c]) - CROSS_BITS'(prod_b[c]);
            if (cross_z[c] == '0)
                c_or[c] = ORI_COLLINEAR;
            else if (cross_z[c][CROSS_BITS-1])
                c_or[c] = ORI_CCW;
            else
                c_or[c] = ORI_CW;
        end
        // proper crossing, or an end point lying on the other segment
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            edge_hit[e] =
                ((edge_info[e].o_start != edge_info[e].o_end) &&
                 (c_or[EDGE_A[e]] != c_or[EDGE_B[e]])) ||
                ((edge_info[e].o_start == ORI_COLLINEAR) && edge_info[e].start_on) ||
                ((edge_info[e].o_end == ORI_COLLINEAR) && edge_info[e].end_on) ||
                ((c_or[EDGE_A[e]] == ORI_COLLINEAR) && corner_on[EDGE_A[e]]) ||
                ((c_or[EDGE_B[e]] == ORI_COLLINEAR) && corner_on[EDGE_B[e]]);
        end
    end

    assign hit = !skip && (|edge_hit);

endmodule

// ===== sv/segment_rectangle_hit_scan.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - top level
// Tests a configured ray segment against a stream of axis-aligned rectangles
// and reports a per-rectangle hit and a sticky hit flag for each run.
// ----------------------------------------------------------------------------
//
//  Channel      Direction  Handshake          Carries
//  rect_in      in         valid/ready        center, size, layer bits, last flag
//  result_out   out        valid/ready        rect_hit, any_hit, run_end
//  APB          in/out     psel/penable       ray end points, ignore mask
//
//  One rectangle per clock while result_out is not stalled; a result is presented
//  after its input transfer passes the input register, product register and result
//  register. The rate is set by the single cross product stage, eight multipliers
//  in parallel.
//  Reset clears the stage valid flags, the configuration registers and the run flag.
//  A stall on result_out holds the pipeline; empty stages still fill, so up to
//  three rectangles are taken before rect_in.ready drops.
//
module segment_rectangle_hit_scan #(
    parameter int COORD_BITS = 16,
    parameter int MASK_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    srhs_rect_if.sink                          rect_in,
    srhs_result_if.source                      result_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srhs_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [srhs_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [srhs_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import srhs_pkg::*;

    localparam int PROD_BITS = 2 * COORD_BITS + 5;

    // configuration
    logic signed [COORD_BITS-1:0] ray_start_x, ray_start_y, ray_end_x, ray_end_y;
    logic [MASK_BITS-1:0]         ignore_mask;

    // input register stage
    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg;
    logic [COORD_BITS-1:0]        rect_width_reg, rect_height_reg;
    logic [MASK_BITS-1:0]         layer_bits_reg;
    logic                         last_rect_reg;

    // product stage
    stage_ctl_t                   prod_ctl;
    logic signed [PROD_BITS-1:0]  prod_a [NUM_CORNERS];
    logic signed [PROD_BITS-1:0]  prod_b [NUM_CORNERS];
    edge_info_t                   edge_info [NUM_EDGES];
    logic                         corner_on [NUM_CORNERS];
    logic                         hit;

    // result stage and run tracking
    logic                         out_valid_reg;
    logic                         rect_hit_reg, any_hit_reg, run_end_reg;
    logic                         hit_seen_reg, hit_seen_next;

    logic                         load_out, load_prod, load_in;

    // Advance a stage when it is empty or the stage after it advances.
    assign load_out  = !out_valid_reg || result_out.ready;
    assign load_prod = !prod_ctl.valid || load_out;
    assign load_in   = !in_valid_reg || load_prod;

    assign rect_in.ready = load_in;

    srhs_cfg_regs #(
        .COORD_BITS (COORD_BITS),
        .MASK_BITS  (MASK_BITS)
    ) u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .ray_start_x (ray_start_x),
        .ray_start_y (ray_start_y),
        .ray_end_x   (ray_end_x),
        .ray_end_y   (ray_end_y),
        .ignore_mask (ignore_mask)
    );

    // Capture an input transfer; the flag tracks whether the stage holds an item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (load_in)
            in_valid_reg <= rect_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_in && rect_in.valid)
        begin
            center_x_reg    <= rect_in.center_x;
            center_y_reg    <= rect_in.center_y;
            rect_width_reg  <= rect_in.rect_width;
            rect_height_reg <= rect_in.rect_height;
            layer_bits_reg  <= rect_in.layer_bits;
            last_rect_reg   <= rect_in.last_rect;
        end
    end

    // Corners, ray cross products, edge orientations; registered inside.
    srhs_geom #(
        .COORD_BITS (COORD_BITS),
        .MASK_BITS  (MASK_BITS)
    ) u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load_prod),
        .in_valid    (in_valid_reg),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .rect_width  (rect_width_reg),
        .rect_height (rect_height_reg),
        .layer_bits  (layer_bits_reg),
        .last_rect   (last_rect_reg),
        .ray_start_x (ray_start_x),
        .ray_start_y (ray_start_y),
        .ray_end_x   (ray_end_x),
        .ray_end_y   (ray_end_y),
        .ignore_mask (ignore_mask),
        .ctl         (prod_ctl),
        .prod_a      (prod_a),
        .prod_b      (prod_b),
        .edge_info   (edge_info),
        .corner_on   (corner_on)
    );

    // Sign the products and combine the edge tests; ignored layers never hit.
    srhs_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .skip      (prod_ctl.skip),
        .prod_a    (prod_a),
        .prod_b    (prod_b),
        .edge_info (edge_info),
        .corner_on (corner_on),
        .hit       (hit)
    );

    // The run flag reports this rectangle's hit too, then drops after the last one.
    assign hit_seen_next = prod_ctl.last ? 1'b0 : (hit_seen_reg || hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_seen_reg  <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= prod_ctl.valid;
            if (prod_ctl.valid)
                hit_seen_reg <= hit_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out && prod_ctl.valid)
        begin
            rect_hit_reg <= hit;
            any_hit_reg  <= hit_seen_reg || hit;
            run_end_reg  <= prod_ctl.last;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.rect_hit = rect_hit_reg;
    assign result_out.any_hit  = any_hit_reg;
    assign result_out.run_end  = run_end_reg;

endmodule

// ===== sv/srhs_checker.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle hit scan - port checker
// Watches the top level's channels and checks the run flag and the stall path.
// ----------------------------------------------------------------------------
`include "segment_rectangle_hit_scan_assert.svh"

module srhs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic rect_hit,
    input logic any_hit,
    input logic run_end
);
    logic run_hit_reg;

    // Track hits seen in the current run from the delivered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_hit_reg <= 1'b0;
        else if (out_valid && out_ready)
            run_hit_reg <= run_end ? 1'b0 : (run_hit_reg || rect_hit);
    end

    `SRHS_ASSERT_IMPL(a_hit_sets_any, clk, rst_n, out_valid && rect_hit, any_hit, "rect_hit without any_hit")
    `SRHS_ASSERT_IMPL(a_any_tracks_run, clk, rst_n, out_valid && out_ready, any_hit == (run_hit_reg || rect_hit), "any_hit disagrees with run history")
    `SRHS_ASSERT_IMPL(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")
    `SRHS_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(rect_hit) && $stable(any_hit) && $stable(run_end), "stalled result changed")

endmodule

bind segment_rectangle_hit_scan srhs_checker u_srhs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (rect_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .rect_hit  (result_out.rect_hit),
    .any_hit   (result_out.any_hit),
    .run_end   (result_out.run_end)
);
